FILE: rtl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// Windowed median filter package
// Shared constants, beat types, cell control types and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

  localparam int HALF_MAX    = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int LINE_DEPTH  = 2 * HALF_MAX + 1;
  localparam int COUNT_SAT   = 2 * HALF_MAX;
  localparam int IDX_W       = $clog2(LINE_DEPTH);
  localparam int CNT_W       = $clog2(LINE_DEPTH + 1);
  localparam int FL_W        = $clog2(HALF_MAX + 1);
  localparam int H_W         = 4;
  localparam int MISS_W      = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [1:0] REG_HALF_WINDOW   = 2'd0;
  localparam logic [1:0] REG_SKIP_MISSING  = 2'd1;
  localparam logic [1:0] REG_MISSING_VALUE = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MISS_W-1:0]      miss_t;

  typedef struct packed {
    sample_t sample;
    logic    is_last;
  } in_beat_t;

  typedef struct packed {
    sample_t value;
    logic    last_out;
  } out_beat_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    sample_t          val;
  } ring_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    logic [H_W-1:0] h;
    logic           skip;
    miss_t          miss;
  } cell_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK,
    ST_MEDIAN,
    ST_CENTER,
    ST_FLUSH
  } wmf_state_e;

endpackage

`default_nettype wire

FILE: rtl/wmf_cell.sv
// ----------------------------------------------------------------------------
// Windowed median filter cell
// Holds one window sample, passes a ranking token around the ring and counts
// how many valid window samples sort below its own sample.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wmf_pkg::cell_ctl_t         ctl_i,
  input  wmf_pkg::cell_cfg_t         cfg_i,
  input  wire [wmf_pkg::IDX_W-1:0]   idx_i,
  input  wmf_pkg::sample_t           line_i,
  input  wmf_pkg::ring_t             ring_i,
  output wmf_pkg::sample_t           line_o,
  output wmf_pkg::ring_t             ring_o,
  output logic                       own_valid_o,
  output logic [wmf_pkg::CNT_W-1:0]  rank_o
);
  import wmf_pkg::*;

  sample_t          line_q;
  ring_t            ring_q;
  logic [CNT_W-1:0] rank_q;
  logic             own_valid;
  logic             less;

  assign own_valid = (idx_i <= IDX_W'({cfg_i.h, 1'b0})) &&
                     !(cfg_i.skip && (line_q == cfg_i.miss));

  assign less = ring_q.valid &&
                ((ring_q.val < line_q) ||
                 ((ring_q.val == line_q) && (ring_q.idx < idx_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      ring_q <= '0;
      rank_q <= '0;
    end else begin
      if (ctl_i.shift) begin
        line_q <= line_i;
      end
      if (ctl_i.load) begin
        ring_q <= '{valid: own_valid, idx: idx_i, val: line_q};
        rank_q <= '0;
      end else if (ctl_i.step) begin
        ring_q <= ring_i;
        rank_q <= rank_q + CNT_W'(less);
      end
    end
  end

  assign line_o      = line_q;
  assign ring_o      = ring_q;
  assign own_valid_o = own_valid;
  assign rank_o      = rank_q;

endmodule

`default_nettype wire

FILE: rtl/wmf_ctrl.sv
// ----------------------------------------------------------------------------
// Windowed median filter controller
// Sequences ranking, median pick, pass-through and end-of-record flush, and
// drives the registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_ctrl (
  input  wire                                               clk_i,
  input  wire                                               rst_ni,
  input  wire                                               in_valid_i,
  input  wmf_pkg::in_beat_t                                 in_beat_i,
  output logic                                              in_stall_o,
  output logic                                              out_valid_o,
  input  wire                                               out_stall_i,
  output wmf_pkg::out_beat_t                                out_beat_o,
  input  wire [wmf_pkg::H_W-1:0]                            h_i,
  input  wmf_pkg::miss_t                                    miss_i,
  input  wmf_pkg::sample_t [wmf_pkg::LINE_DEPTH-1:0]        line_i,
  input  wire [wmf_pkg::LINE_DEPTH-1:0]                     own_valid_i,
  input  wire [wmf_pkg::LINE_DEPTH-1:0][wmf_pkg::CNT_W-1:0] rank_i,
  input  wire                                               ring_valid0_i,
  output wmf_pkg::cell_ctl_t                                ctl_o
);
  import wmf_pkg::*;

  wmf_state_e       state_q, state_d;
  logic [CNT_W-1:0] rcnt_q, rcnt_d;
  logic [CNT_W-1:0] c_q, c_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [FL_W-1:0]  fl_q, fl_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic             accept;
  logic             free;
  logic             emit;
  logic             emit_last;
  sample_t          emit_val;
  sample_t          med;
  logic [CNT_W-1:0] half_c;
  logic [CNT_W-1:0] two_h;
  logic [CNT_W-1:0] h_ext;
  logic [IDX_W-1:0] ptr;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign free   = !out_valid_q || !out_stall_i;
  assign half_c = c_q >> 1;
  assign two_h  = CNT_W'({h_i, 1'b0});
  assign h_ext  = CNT_W'(h_i);

  always_comb begin
    med = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      if (own_valid_i[i] && (rank_i[i] == half_c)) begin
        med = med | line_i[i];
      end
    end
    if (c_q == '0) begin
      med = SAMPLE_BITS'(miss_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    rcnt_d    = rcnt_q;
    c_d       = c_q;
    step_d    = step_q;
    fl_d      = fl_q;
    last_d    = last_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    ptr       = IDX_W'(h_i);
    ctl_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctl_o.shift = 1'b1;
          last_d      = in_beat_i.is_last;
          if (!in_beat_i.is_last) begin
            fl_d = '0;
          end else if (rcnt_q >= h_ext) begin
            fl_d = FL_W'(h_i);
          end else begin
            fl_d = FL_W'(rcnt_q + 1'b1);
          end
          if ((h_i == '0) || in_beat_i.is_last) begin
            rcnt_d = '0;
          end else if (rcnt_q >= CNT_W'(COUNT_SAT)) begin
            rcnt_d = CNT_W'(COUNT_SAT);
          end else begin
            rcnt_d = rcnt_q + 1'b1;
          end
          if (h_i == '0) begin
            state_d = ST_CENTER;
          end else if (rcnt_q >= two_h) begin
            state_d = ST_LOAD;
          end else if (rcnt_q >= h_ext) begin
            state_d = ST_CENTER;
          end else if (in_beat_i.is_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_LOAD: begin
        ctl_o.load = 1'b1;
        step_d     = '0;
        c_d        = '0;
        state_d    = ST_RANK;
      end
      ST_RANK: begin
        ctl_o.step = 1'b1;
        c_d        = c_q + CNT_W'(ring_valid0_i);
        step_d     = step_q + 1'b1;
        if (step_q == IDX_W'(LINE_DEPTH - 1)) begin
          state_d = ST_MEDIAN;
        end
      end
      ST_MEDIAN, ST_CENTER: begin
        if (free) begin
          emit      = 1'b1;
          emit_last = last_q && (fl_q == '0);
          state_d   = (fl_q != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        ptr = IDX_W'(fl_q - 1'b1);
        if (free) begin
          emit      = 1'b1;
          emit_last = last_q && (fl_q == FL_W'(1));
          fl_d      = fl_q - 1'b1;
          if (fl_q == FL_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    emit_val = (state_q == ST_MEDIAN) ? med : line_i[ptr];
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d    = 1'b1;
      out_d.value    = emit_val;
      out_d.last_out = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rcnt_q      <= '0;
      c_q         <= '0;
      step_q      <= '0;
      fl_q        <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rcnt_q      <= rcnt_d;
      c_q         <= c_d;
      step_q      <= step_d;
      fl_q        <= fl_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/windowed_median_filter_unit.sv
// Order: a median beat passes a load step, a ranking step for each cell of the ring, a
// pick step and the output register after its input is taken. Pass-through beats skip
// the ranking and go to the output register; the end-of-record flush sends one beat per
// cycle while the output is not stalled. A new input is taken only once the controller
// is back in idle, so once the window is full the ranking ring sets the input rate.
// Reset clears the window, sample count and output valid; registers return to defaults.
// ----------------------------------------------------------------------------
// Windowed median filter unit
// Top level with the register port, the row of window cells and the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_median_filter_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wmf_pkg::in_beat_t            in_beat_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output wmf_pkg::out_beat_t           out_beat_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [wmf_pkg::ADDR_W-1:0]    paddr,
  input  wire [wmf_pkg::DATA_W-1:0]    pwdata,
  output logic [wmf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import wmf_pkg::*;

  logic [H_W-1:0] half_q;
  logic           skip_q;
  miss_t          miss_q;
  logic [H_W-1:0] h_eff;
  logic           wr_en;
  cell_cfg_t      cfg;
  cell_ctl_t      ctl;

  sample_t [LINE_DEPTH-1:0]             line;
  ring_t   [LINE_DEPTH-1:0]             ring;
  logic    [LINE_DEPTH-1:0]             own_valid;
  logic    [LINE_DEPTH-1:0][CNT_W-1:0]  rank;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= H_W'(1);
      skip_q <= 1'b0;
      miss_q <= 16'sh8000;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HALF_WINDOW:   half_q <= pwdata[H_W-1:0];
        REG_SKIP_MISSING:  skip_q <= pwdata[0];
        REG_MISSING_VALUE: miss_q <= pwdata[MISS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HALF_WINDOW:   prdata = DATA_W'(half_q);
      REG_SKIP_MISSING:  prdata = DATA_W'(skip_q);
      REG_MISSING_VALUE: prdata = DATA_W'(miss_q);
      default:           prdata = '0;
    endcase
  end

  assign h_eff = (half_q > H_W'(HALF_MAX)) ? H_W'(HALF_MAX) : half_q;
  assign cfg   = '{h: h_eff, skip: skip_q, miss: miss_q};

  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
    wmf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cfg_i       (cfg),
      .idx_i       (IDX_W'(g)),
      .line_i      ((g == 0) ? in_beat_i.sample : line[(g + LINE_DEPTH - 1) % LINE_DEPTH]),
      .ring_i      (ring[(g + LINE_DEPTH - 1) % LINE_DEPTH]),
      .line_o      (line[g]),
      .ring_o      (ring[g]),
      .own_valid_o (own_valid[g]),
      .rank_o      (rank[g])
    );
  end

  wmf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_beat_i     (in_beat_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_beat_o    (out_beat_o),
    .h_i           (h_eff),
    .miss_i        (miss_q),
    .line_i        (line),
    .own_valid_i   (own_valid),
    .rank_i        (rank),
    .ring_valid0_i (ring[0].valid),
    .ctl_o         (ctl)
  );

endmodule

`default_nettype wire

FILE: rtl/wmf_checker.sv
// ----------------------------------------------------------------------------
// Windowed median filter checker
// Port-level assertions for the filter unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_stall_o,
  input wmf_pkg::in_beat_t           in_beat_i,
  input wire                         out_valid_o,
  input wire                         out_stall_i,
  input wmf_pkg::out_beat_t          out_beat_o,
  input wire                         psel,
  input wire                         penable,
  input wire                         pwrite,
  input wire [wmf_pkg::ADDR_W-1:0]   paddr,
  input wire [wmf_pkg::DATA_W-1:0]   pwdata,
  input wire [wmf_pkg::DATA_W-1:0]   prdata,
  input wire                         pready
);
  import wmf_pkg::*;

  // A new output beat is only produced while the input side is busy.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat appeared while the input side was idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)))
    else $error("stalled output beat changed");

  a_half_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[3:2] == REG_HALF_WINDOW))
      |=> ((paddr[3:2] != REG_HALF_WINDOW) || (prdata[H_W-1:0] == $past(pwdata[H_W-1:0]))))
    else $error("half window register did not read back its written value");

  a_miss_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[3:2] == REG_MISSING_VALUE))
      |=> ((paddr[3:2] != REG_MISSING_VALUE) ||
           (prdata[MISS_W-1:0] == $past(pwdata[MISS_W-1:0]))))
    else $error("missing value register did not read back its written value");

endmodule

bind windowed_median_filter_unit wmf_checker u_wmf_checker (.*);

`default_nettype wire

FILE: test/windowed_median_filter_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed median filter result checker
// Watches the register port and both beat channels of the filter. It keeps its
// own copy of the sample window, the in-record sample count and the register settings,
// predicts the result beats of every accepted input beat, and compares each
// accepted result beat with the oldest prediction. It reports mismatch counts
// and the number of predictions still outstanding.
// ----------------------------------------------------------------------------

module windowed_median_filter_unit_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  wmf_pkg::in_beat_t          in_beat_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  wmf_pkg::out_beat_t         out_beat_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [wmf_pkg::ADDR_W-1:0] paddr_i,
  input  logic [wmf_pkg::DATA_W-1:0] pwdata_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         in_beats_o,
  output int                         out_beats_o
);
  import wmf_pkg::*;

  sample_t        line_q [LINE_DEPTH];
  int unsigned    seen_cnt;
  logic [H_W-1:0] cfg_half;
  logic           cfg_skip;
  miss_t          cfg_miss;
  out_beat_t      filtered_q [$];
  int             err_cnt = 0;
  int             in_cnt  = 0;
  int             out_cnt = 0;
  int             pend_cnt = 0;

  assign errors_o    = err_cnt;
  assign pending_o   = pend_cnt;
  assign in_beats_o  = in_cnt;
  assign out_beats_o = out_cnt;

  function automatic void note_failure(string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic sample_t median_of_window(int unsigned h);
    sample_t vals [LINE_DEPTH];
    sample_t v;
    int      c;
    int      j;
    c = 0;
    for (int i = 0; i <= 2 * h && i < LINE_DEPTH; i++) begin
      if (!(cfg_skip && line_q[i] == cfg_miss)) begin
        vals[c] = line_q[i];
        c++;
      end
    end
    if (c == 0) begin
      return sample_t'(cfg_miss);
    end
    for (int i = 1; i < c; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[c / 2];
  endfunction

  function automatic void push_filtered(sample_t v, logic last);
    out_beat_t r;
    r.value    = v;
    r.last_out = last;
    filtered_q = {filtered_q, r};
  endfunction

  function automatic void predict_beat(in_beat_t b);
    int unsigned h;
    int unsigned n;
    int unsigned idx;
    h = (cfg_half > HALF_MAX) ? HALF_MAX : cfg_half;
    n = seen_cnt;
    for (int i = LINE_DEPTH - 1; i > 0; i--) begin
      line_q[i] = line_q[i-1];
    end
    line_q[0] = b.sample;
    if (h == 0) begin
      push_filtered(b.sample, b.is_last);
      seen_cnt = 0;
      return;
    end
    if (n >= h) begin
      push_filtered((n >= 2 * h) ? median_of_window(h) : line_q[h], 1'b0);
    end
    if (b.is_last) begin
      idx = (n >= h) ? h : n + 1;
      while (idx > 0) begin
        idx--;
        push_filtered(line_q[idx], idx == 0);
      end
      seen_cnt = 0;
    end else begin
      seen_cnt = (n + 1 > COUNT_SAT) ? COUNT_SAT : n + 1;
    end
  endfunction

  function automatic void check_result(out_beat_t got);
    out_beat_t want;
    out_cnt++;
    if (filtered_q.size() == 0) begin
      note_failure($sformatf("Unexpected result beat: value %0d last_out %0b",
                             got.value, got.last_out));
      return;
    end
    want = filtered_q.pop_front();
    if (got.value !== want.value || got.last_out !== want.last_out) begin
      note_failure($sformatf({"Mismatch on result beat %0d: value %0d (expected %0d), ",
                              "last_out %0b (expected %0b)"},
                             out_cnt, got.value, want.value, got.last_out, want.last_out));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (line_q[i]) begin
        line_q[i] = '0;
      end
      seen_cnt = 0;
      cfg_half = 4'd1;
      cfg_skip = 1'b0;
      cfg_miss = 16'sh8000;
      filtered_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_HALF_WINDOW: begin
            cfg_half = pwdata_i[H_W-1:0];
          end
          REG_SKIP_MISSING: begin
            cfg_skip = pwdata_i[0];
          end
          REG_MISSING_VALUE: begin
            cfg_miss = pwdata_i[MISS_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_beat_i);
      end
      if (in_valid_i && !in_stall_i) begin
        predict_beat(in_beat_i);
        in_cnt++;
      end
    end
    pend_cnt = filtered_q.size();
  end

endmodule

FILE: test/windowed_median_filter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed median filter unit testbench
// Drives sample records into the filter with random gaps, stalls the result
// channel at random and rewrites the registers between phases and inside
// records. A directed opening covers the field extremes, pass-through cases
// and missing-value handling; random records with random settings follow.
// The checker beside the filter predicts and compares every result beat.
// ----------------------------------------------------------------------------

module windowed_median_filter_unit_test;
  import wmf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_BEATS = 400;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_beat_t          in_beat  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_beat;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   errors;
  int   pending;
  int   in_beats;
  int   out_beats;
  int   cycle_cnt    = 0;
  int   settings_cnt = 0;
  int   sent_cnt     = 0;
  int   stall_left   = 0;
  int   free_left    = 0;
  int   stall_pick;
  logic stall_next;

  always #5 clk = ~clk;

  windowed_median_filter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  windowed_median_filter_unit_checker u_filter_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .in_beats_o  (in_beats),
    .out_beats_o (out_beats)
  );

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      stall_next = 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 8) begin
        stall_left = $urandom_range(15, 40) - 1;
        stall_next = 1'b1;
      end else if (stall_pick < 45) begin
        stall_left = $urandom_range(1, 3) - 1;
        stall_next = 1'b1;
      end else if (stall_pick < 90) begin
        free_left  = $urandom_range(1, 6) - 1;
        stall_next = 1'b0;
      end else begin
        free_left  = $urandom_range(30, 120) - 1;
        stall_next = 1'b0;
      end
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result beats outstanding", cycle_cnt, pending);
      $display("windowed_median_filter_unit_test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
  endtask

  task automatic apply_settings(int h, bit skip, miss_t miss);
    write_reg(REG_HALF_WINDOW, DATA_W'(h));
    write_reg(REG_SKIP_MISSING, DATA_W'(skip));
    write_reg(REG_MISSING_VALUE, {{(DATA_W - MISS_W){1'b0}}, miss});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int gap_len(bit burst);
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 40);
  endfunction

  task automatic send_sample(sample_t s, logic last, bit burst);
    in_beat_t b;
    int       gap;
    logic     taken;
    b.sample  = s;
    b.is_last = last;
    gap = gap_len(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent_cnt++;
  endtask

  function automatic sample_t rand_sample(bit skip, miss_t miss);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (skip && r < 30) begin
      return sample_t'(miss);
    end else if (r < 65) begin
      v = int'($urandom_range(0, 15)) - 8;
      return sample_t'(v);
    end
    return sample_t'($urandom());
  endfunction

  task automatic send_run(int len, bit ends_record, bit skip, miss_t miss, bit burst);
    for (int k = 0; k < len; k++) begin
      send_sample(rand_sample(skip, miss), ends_record && (k == len - 1), burst);
    end
  endtask

  function automatic int pick_half();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 0;
    end else if (r < 13) begin
      return $urandom_range(1, 4);
    end else if (r < 17) begin
      return $urandom_range(5, 8);
    end
    return $urandom_range(9, 15);
  endfunction

  function automatic miss_t pick_missing();
    int r;
    int v;
    r = $urandom_range(0, 5);
    if (r == 0) begin
      return 16'sh8000;
    end else if (r == 1) begin
      return 16'sh7fff;
    end else if (r == 2) begin
      return miss_t'($urandom());
    end
    v = int'($urandom_range(0, 6)) - 3;
    return miss_t'(v);
  endfunction

  function automatic int pick_len(int h);
    int he;
    int r;
    he = (h > HALF_MAX) ? HALF_MAX : h;
    if (he == 0) begin
      return $urandom_range(1, 10);
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 2 * he + 1 + $urandom_range(0, 8);
    end else if (r < 90) begin
      return $urandom_range(1, 2 * he);
    end
    return $urandom_range(18, 40);
  endfunction

  initial begin
    int    goal;
    int    h;
    int    nrec;
    int    len;
    int    cut;
    bit    skip;
    bit    burst;
    miss_t miss;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the settings left by reset.
    send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh0001, 1'b1, 1'b0);
    wait_drained();

    apply_settings(0, 1'b0, 16'sh8000);
    send_sample(16'shffff, 1'b0, 1'b0);
    send_sample(16'sh7fff, 1'b1, 1'b0);
    wait_drained();

    // Every window made of missing samples, then missing samples mixed with others.
    apply_settings(2, 1'b1, 16'sd7);
    for (int k = 0; k < 6; k++) begin
      send_sample(16'sd7, k == 5, 1'b0);
    end
    wait_drained();
    send_sample(16'sd7, 1'b0, 1'b0);
    send_sample(16'sd3, 1'b0, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b0);
    send_sample(-16'sd4, 1'b0, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b0);
    send_sample(16'sd9, 1'b1, 1'b0);
    wait_drained();

    // Oversized half window turns this record into a short one.
    apply_settings(15, 1'b0, 16'sh7fff);
    send_sample(16'sh7fff, 1'b0, 1'b1);
    send_sample(16'sh8000, 1'b0, 1'b1);
    send_sample(16'sh7fff, 1'b0, 1'b1);
    send_sample(16'sd100, 1'b0, 1'b1);
    send_sample(-16'sd100, 1'b1, 1'b1);
    wait_drained();

    // Half window changed in the middle of a record.
    apply_settings(3, 1'b0, 16'sh8000);
    send_sample(16'sd5, 1'b0, 1'b0);
    send_sample(-16'sd5, 1'b0, 1'b0);
    wait_drained();
    apply_settings(1, 1'b0, 16'sh8000);
    send_sample(16'sd9, 1'b0, 1'b0);
    send_sample(-16'sd9, 1'b0, 1'b0);
    send_sample(16'sd0, 1'b1, 1'b0);
    wait_drained();

    apply_settings(8, 1'b1, 16'sh8000);
    send_sample(16'sh8000, 1'b1, 1'b0);
    wait_drained();

    goal = sent_cnt + RANDOM_BEATS;
    while (sent_cnt < goal) begin
      h    = pick_half();
      skip = $urandom_range(0, 1);
      miss = pick_missing();
      apply_settings(h, skip, miss);
      burst = ($urandom_range(0, 3) == 0);
      nrec  = $urandom_range(2, 5);
      for (int rec = 0; rec < nrec; rec++) begin
        len = pick_len(h);
        if (rec == 0 && len > 1 && $urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, len - 1);
          send_run(cut, 1'b0, skip, miss, burst);
          wait_drained();
          h = pick_half();
          apply_settings(h, skip, miss);
          send_run(len - cut, 1'b1, skip, miss, burst);
        end else begin
          send_run(len, 1'b1, skip, miss, burst);
        end
      end
      wait_drained();
    end

    $display("Covered %0d input beats and %0d result beats over %0d register settings,",
             in_beats, out_beats, settings_cnt);
    $display("including zero, full and oversized half windows and missing-value skipping.");
    if (errors == 0) begin
      $display("windowed_median_filter_unit_test passed");
    end else begin
      $display("%0d result beats failed their check", errors);
      $display("windowed_median_filter_unit_test failed");
    end
    $finish;
  end

endmodule
